>>> src/psk31_pkg.sv
// Shared types, constants and lookup tables of the PSK31 varicode phase encoder.
package psk31_pkg;

    localparam int CODE_W  = 10;
    localparam int SHIFT_W = CODE_W + 2;
    localparam int CNT_W   = 4;
    localparam int HIST_W  = 5;

    localparam logic MODE_BPSK = 1'b0;
    localparam logic MODE_QPSK = 1'b1;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_RAW  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [6:0] char_code;
        logic       raw_bit;
    } item_word_t;

    typedef struct packed {
        logic [1:0] phase_quadrant;
        logic       coded_bit;
        logic       phase_changed;
        logic       last_of_run;
    } symbol_word_t;

    typedef struct packed {
        logic valid;
        logic bit_value;
        logic last;
    } bit_req_t;

    localparam logic [CODE_W-1:0] VARICODE_TAB [128] = '{
        10'h2AB, 10'h2DB, 10'h2ED, 10'h377, 10'h2EB, 10'h35F, 10'h2EF, 10'h2FD,
        10'h2FF, 10'h0EF, 10'h01D, 10'h36F, 10'h2DD, 10'h01F, 10'h375, 10'h3AB,
        10'h2F7, 10'h2F5, 10'h3AD, 10'h3AF, 10'h35B, 10'h36B, 10'h36D, 10'h357,
        10'h37B, 10'h37D, 10'h3B7, 10'h355, 10'h35D, 10'h3BB, 10'h2FB, 10'h37F,
        10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
        10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
        10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
        10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
        10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
        10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
        10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
        10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
        10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
        10'h02B, 10'h00D, 10'h1EB, 10'h0BF, 10'h01B, 10'h03B, 10'h00F, 10'h007,
        10'h03F, 10'h1BF, 10'h015, 10'h017, 10'h005, 10'h037, 10'h07B, 10'h06B,
        10'h0DF, 10'h05D, 10'h1D5, 10'h2B7, 10'h1BB, 10'h2B5, 10'h2D7, 10'h3B5
    };

    localparam logic [1:0] CONV_DELTA [32] = '{
        2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd0, 2'd2, 2'd1,
        2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3,
        2'd1, 2'd2, 2'd0, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2,
        2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0
    };

    // Position of the highest set bit plus one; an all-zero code counts as one bit.
    function automatic logic [CNT_W-1:0] code_length(input logic [CODE_W-1:0] code);
        logic [CNT_W-1:0] len;
        len = CNT_W'(1);
        for (int i = 0; i < CODE_W; i++)
        begin
            if (code[i])
            begin
                len = CNT_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

>>> src/psk31_if.sv
// Valid/ready channel interfaces for input items and output symbols.
interface psk31_item_if;
    import psk31_pkg::*;
    logic       valid;
    logic       ready;
    item_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psk31_symbol_if;
    import psk31_pkg::*;
    logic         valid;
    logic         ready;
    symbol_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/psk31_varicode_phase_encoder.sv
// Top level of the PSK31 varicode encoder with BPSK and QPSK phase mapping.
// Each accepted word either encodes a character or sends one raw bit. A character
// produces its varicode bits, most significant set bit first, followed by two zero
// separator bits, so it yields its code length plus two bits (3 to 12), and a raw
// word yields a single bit. The shift register in the serializer sends one bit per
// cycle while the phase mapper takes it; a new word is accepted the cycle after the
// last bit of the previous one has entered the output register. Every symbol word
// carries the carrier quadrant, the bit it carries, a phase change flag and a flag on
// the last symbol of its input word. The mode register selects BPSK or QPSK and should
// only be written while no symbols are pending.
module psk31_varicode_phase_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mode_we,
    input  logic           mode_wdata,
    psk31_item_if.sink     item,
    psk31_symbol_if.source symbol
);
    import psk31_pkg::*;

    logic     mode_reg;
    bit_req_t req;
    logic     take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BPSK;
        end
        else if (mode_we)
        begin
            mode_reg <= mode_wdata;
        end
    end

    psk31_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .req   (req),
        .take  (take)
    );

    psk31_phase_mapper u_phase_mapper (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode_reg),
        .req    (req),
        .take   (take),
        .symbol (symbol)
    );

endmodule

>>> src/psk31_serializer.sv
// Varicode lookup and bit shift register that feeds one bit per cycle while the mapper takes it.
module psk31_serializer (
    input  logic               clk,
    input  logic               rst_n,
    psk31_item_if.sink         item,
    output psk31_pkg::bit_req_t req,
    input  logic               take
);
    import psk31_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SHIFT_W-1:0] shift_reg;
    logic [SHIFT_W-1:0] shift_next;
    logic [CODE_W-1:0]  code;
    logic [CNT_W-1:0]   len;
    logic               accept;

    assign item.ready    = (count_reg == '0);
    assign accept        = item.valid && item.ready;
    assign req.valid     = (count_reg != '0);
    assign req.bit_value = shift_reg[SHIFT_W-1];
    assign req.last      = (count_reg == CNT_W'(1));

    assign code = VARICODE_TAB[item.data.char_code];
    assign len  = code_length(code);

    always_comb
    begin
        count_next = count_reg;
        shift_next = shift_reg;
        if (accept)
        begin
            if (item.data.command == CMD_RAW)
            begin
                shift_next = {item.data.raw_bit, {(SHIFT_W-1){1'b0}}};
                count_next = CNT_W'(1);
            end
            else
            begin
                // Left-align the code so its leading one leaves first, separators trail.
                shift_next = {code, 2'b00} << (CNT_W'(CODE_W) - len);
                count_next = len + CNT_W'(2);
            end
        end
        else if (req.valid && take)
        begin
            shift_next = {shift_reg[SHIFT_W-2:0], 1'b0};
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

>>> src/psk31_phase_mapper.sv
// Maps each bit to a BPSK or QPSK carrier phase and holds the output word register.
module psk31_phase_mapper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mode,
    input  psk31_pkg::bit_req_t req,
    output logic               take,
    psk31_symbol_if.source     symbol
);
    import psk31_pkg::*;

    logic               out_valid_reg;
    logic               out_valid_next;
    symbol_word_t       out_word_reg;
    symbol_word_t       out_word_next;
    logic               bpsk_toggle_reg;
    logic               bpsk_toggle_next;
    logic [1:0]         qpsk_phase_reg;
    logic [1:0]         qpsk_phase_next;
    logic [HIST_W-1:0]  hist_reg;
    logic [HIST_W-1:0]  hist_next;
    logic [HIST_W-1:0]  hist_shift;
    logic [1:0]         delta;
    logic [1:0]         phase_sum;
    logic               fire;

    assign take         = !out_valid_reg || symbol.ready;
    assign fire         = req.valid && take;
    assign symbol.valid = out_valid_reg;
    assign symbol.data  = out_word_reg;

    assign hist_shift = {hist_reg[HIST_W-2:0], req.bit_value};
    assign delta      = CONV_DELTA[hist_shift];
    assign phase_sum  = qpsk_phase_reg + delta;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_word_next    = out_word_reg;
        bpsk_toggle_next = bpsk_toggle_reg;
        qpsk_phase_next  = qpsk_phase_reg;
        hist_next        = hist_reg;
        if (fire)
        begin
            out_valid_next            = 1'b1;
            out_word_next.coded_bit   = req.bit_value;
            out_word_next.last_of_run = req.last;
            if (mode == MODE_BPSK)
            begin
                out_word_next.phase_quadrant = (req.bit_value ^ bpsk_toggle_reg) ? 2'd2 : 2'd0;
                out_word_next.phase_changed  = !req.bit_value;
                bpsk_toggle_next = bpsk_toggle_reg ^ !req.bit_value;
            end
            else
            begin
                out_word_next.phase_quadrant = phase_sum;
                out_word_next.phase_changed  = (delta != 2'd0);
                hist_next       = hist_shift;
                qpsk_phase_next = phase_sum;
            end
        end
        else if (symbol.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            bpsk_toggle_reg <= 1'b0;
            qpsk_phase_reg  <= 2'd0;
            hist_reg        <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            bpsk_toggle_reg <= bpsk_toggle_next;
            qpsk_phase_reg  <= qpsk_phase_next;
            hist_reg        <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

>>> test/tb_psk31_varicode_phase_encoder.sv
// Self-checking testbench of the PSK31 varicode phase encoder in both phase modes.
`timescale 1ns / 100ps

module tb_psk31_varicode_phase_encoder;
    import psk31_pkg::*;

    localparam logic [1:0] QUAD_ZERO = 2'd0;
    localparam logic [1:0] QUAD_180  = 2'd2;
    localparam int HOLD_AFTER_WORDS  = 40;
    localparam int HOLD_CYCLES       = 300;
    localparam int SETTLE_CYCLES     = 16;

    logic clk;
    logic rst_n;
    logic mode_we;
    logic mode_wdata;

    psk31_item_if   item_ch ();
    psk31_symbol_if sym_ch ();

    psk31_varicode_phase_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .item       (item_ch.sink),
        .symbol     (sym_ch.source)
    );

    item_word_t   pending_items [$];
    symbol_word_t expected_symbols [$];

    int   words_queued   = 0;
    int   words_accepted = 0;
    int   error_count    = 0;
    logic item_fire      = 1'b0;

    logic       active_mode = MODE_BPSK;
    logic       bpsk_ref    = 1'b0;
    logic [1:0] qpsk_quad   = 2'd0;
    logic [4:0] bit_history = 5'd0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("psk31_varicode_phase_encoder verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic encode_bit(input logic b, input logic last);
        symbol_word_t s;
        logic [1:0]   delta;
        s.coded_bit   = b;
        s.last_of_run = last;
        if (active_mode == MODE_BPSK)
        begin
            s.phase_quadrant = (b ^ bpsk_ref) ? QUAD_180 : QUAD_ZERO;
            s.phase_changed  = ~b;
            if (!b)
            begin
                bpsk_ref = ~bpsk_ref;
            end
        end
        else
        begin
            bit_history      = {bit_history[3:0], b};
            delta            = CONV_DELTA[bit_history];
            qpsk_quad        = qpsk_quad + delta;
            s.phase_quadrant = qpsk_quad;
            s.phase_changed  = (delta != 2'd0);
        end
        expected_symbols = {expected_symbols, s};
    endtask

    task automatic expand_item(input item_word_t w);
        logic [CODE_W-1:0] code;
        int                len;
        if (w.command == CMD_RAW)
        begin
            encode_bit(w.raw_bit, 1'b1);
        end
        else
        begin
            code = VARICODE_TAB[w.char_code];
            len  = 1;
            for (int i = CODE_W - 1; i >= 0; i--)
            begin
                if (code[i] && len == 1)
                begin
                    len = i + 1;
                    break;
                end
            end
            for (int i = len - 1; i >= 0; i--)
            begin
                encode_bit(code[i], 1'b0);
            end
            encode_bit(1'b0, 1'b0);
            encode_bit(1'b0, 1'b1);
        end
    endtask

    // Predicts on every accepted input word and checks every accepted symbol word.
    always @(posedge clk)
    begin : monitor
        symbol_word_t got;
        symbol_word_t want;
        item_fire = item_ch.valid && item_ch.ready && rst_n;
        if (mode_we && rst_n)
        begin
            active_mode = mode_wdata;
        end
        if (item_fire)
        begin
            expand_item(item_ch.data);
            words_accepted++;
        end
        if (sym_ch.valid && sym_ch.ready && rst_n)
        begin
            got = sym_ch.data;
            if (expected_symbols.size() == 0)
            begin
                report_mismatch($sformatf("unexpected symbol word %h", got));
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (got.phase_quadrant !== want.phase_quadrant)
                begin
                    report_mismatch($sformatf("phase_quadrant %h, want %h",
                                              got.phase_quadrant, want.phase_quadrant));
                end
                if (got.coded_bit !== want.coded_bit)
                begin
                    report_mismatch($sformatf("coded_bit %b, want %b",
                                              got.coded_bit, want.coded_bit));
                end
                if (got.phase_changed !== want.phase_changed)
                begin
                    report_mismatch($sformatf("phase_changed %b, want %b",
                                              got.phase_changed, want.phase_changed));
                end
                if (got.last_of_run !== want.last_of_run)
                begin
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              got.last_of_run, want.last_of_run));
                end
            end
        end
    end

    // The sender offers words in bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : driver
        static int  burst_left = 1;
        static int  gap_left   = 0;
        item_word_t next_data;
        logic       next_valid;
        if (!item_ch.valid || item_fire)
        begin
            next_valid = 1'b0;
            next_data  = item_ch.data;
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (pending_items.size() != 0)
            begin
                next_data  = pending_items.pop_front();
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            item_ch.valid <= next_valid;
            item_ch.data  <= next_data;
        end
    end

    // The receiver changes its stall style now and then and holds off once for a long time.
    always @(negedge clk)
    begin : receiver
        static int  hold_left  = 0;
        static bit  hold_done  = 1'b0;
        static int  style      = 0;
        static int  style_left = 0;
        static int  period     = 3;
        static int  tick       = 0;
        logic       next_ready;
        if (hold_left != 0)
        begin
            hold_left--;
            next_ready = 1'b0;
        end
        else if (!hold_done && words_accepted >= HOLD_AFTER_WORDS)
        begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            next_ready = 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 2);
                style_left = $urandom_range(20, 80);
                period     = $urandom_range(2, 5);
            end
            else
            begin
                style_left--;
            end
            tick++;
            case (style)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                default: next_ready = (tick % period) != 0;
            endcase
        end
        sym_ch.ready <= next_ready;
    end

    task automatic offer(input logic cmd, input logic [6:0] ch, input logic rb);
        item_word_t w;
        w.command   = cmd;
        w.char_code = ch;
        w.raw_bit   = rb;
        pending_items = {pending_items, w};
        words_queued++;
    endtask

    task automatic queue_directed();
        offer(CMD_RAW, 7'h7F, 1'b0);
        offer(CMD_RAW, 7'h00, 1'b0);
        offer(CMD_RAW, 7'h55, 1'b1);
        offer(CMD_CHAR, 7'h00, 1'b1);
        offer(CMD_CHAR, 7'h7F, 1'b0);
        offer(CMD_CHAR, 7'h20, 1'b1);
        offer(CMD_CHAR, 7'h65, 1'b0);
        offer(CMD_CHAR, 7'h0A, 1'b1);
        offer(CMD_RAW, 7'h2A, 1'b1);
        offer(CMD_RAW, 7'h7F, 1'b1);
    endtask

    // Mostly characters, interleaved at random with runs of raw zero bits and raw one bits.
    task automatic queue_random(input int count);
        int kind;
        int run;
        int done;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                run = $urandom_range(2, 6);
                for (int i = 0; i < run; i++)
                begin
                    offer(CMD_RAW, 7'($urandom), (kind == 2));
                end
                done += run;
            end
            else
            begin
                offer(CMD_CHAR, 7'($urandom), 1'($urandom));
                done++;
            end
        end
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(negedge clk);
        mode_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic random_modes [4];
        random_modes = '{MODE_QPSK, MODE_BPSK, MODE_QPSK, MODE_BPSK};
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        sym_ch.ready  = 1'b0;
        mode_we       = 1'b0;
        mode_wdata    = MODE_BPSK;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(MODE_BPSK);
        queue_directed();
        wait_idle();
        write_mode(MODE_QPSK);
        queue_directed();
        wait_idle();
        for (int p = 0; p < 4; p++)
        begin
            write_mode(random_modes[p]);
            queue_random(20);
            wait_idle();
        end

        if (error_count == 0)
        begin
            $display("psk31_varicode_phase_encoder verification clean");
        end
        else
        begin
            $display("psk31_varicode_phase_encoder verification failed");
        end
        $finish;
    end

endmodule

>>> psk31_varicode_phase_encoder.f
src/psk31_pkg.sv
src/psk31_if.sv
src/psk31_serializer.sv
src/psk31_phase_mapper.sv
src/psk31_varicode_phase_encoder.sv
test/tb_psk31_varicode_phase_encoder.sv
